// File: rtl/clat_pkg.sv
// clat_pkg: shared types, widths and constants of the cpu load average tracker
// used by clat_div and cpu_load_average_tracker; no dependencies
package clat_pkg;

  // fixed scaling and limits
  localparam int NUM_SETS_DEF = 8;
  localparam int SCALE        = 1000;
  localparam int SCHED_BITS   = 8;
  localparam int MAX_CPUS     = 64;
  localparam int MAX_WAITING  = 4095;
  localparam int OLD_PARTS    = 4;
  localparam int ALL_PARTS    = 5;
  localparam int NUM_SYS      = 3;

  // field widths
  localparam int SET_W   = 3;
  localparam int CPU_W   = 7;
  localparam int WAIT_W  = 12;
  localparam int NTHR_W  = 13;
  localparam int FAC_W   = 17;
  localparam int LOAD_W  = 23;
  localparam int AVG_W   = 22;
  localparam int SCHED_W = 21;
  localparam int SCALE_W = 10;
  localparam int CFG_DW  = 10;
  localparam int CFG_AW  = 2;
  localparam int SYS_W   = 2;

  // shared divider and multiplier
  localparam int DIV_DW    = 33;
  localparam int DIV_SW    = 13;
  localparam int DIV_CNT_W = 6;
  localparam int MUL_AW    = 23;
  localparam int MUL_PW    = MUL_AW + SCALE_W;

  // quotient bits per division
  localparam int N_FAC   = 17;
  localparam int N_SCHED = 21;
  localparam int N_AVG   = 22;
  localparam int N_SF    = 20;
  localparam int N_SL    = 26;
  localparam int N_SYSF  = 27;
  localparam int N_SYSL  = 33;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DEFAULT_SET = 2'd0,
    CFG_DECAY_SHORT = 2'd1,
    CFG_DECAY_MID   = 2'd2,
    CFG_DECAY_LONG  = 2'd3
  } clat_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FAC_MUL,
    ST_FAC_DIV,
    ST_SCHED_DIV,
    ST_AVG_DIV,
    ST_SF_DIV,
    ST_SL_DIV,
    ST_SYS_FA,
    ST_SYS_FB,
    ST_SYS_FD,
    ST_SYS_FW,
    ST_SYS_LB,
    ST_SYS_LD,
    ST_SYS_LW,
    ST_WB,
    ST_OUT
  } clat_state_e;

  typedef struct packed {
    logic [SET_W-1:0]  set_index;
    logic [CPU_W-1:0]  cpu_count;
    logic [WAIT_W-1:0] waiting_threads;
    logic [CPU_W-1:0]  idle_cpus;
  } in_t;

  typedef struct packed {
    logic                skipped;
    logic [15:0]         set_factor_avg;
    logic [21:0]         set_load_avg;
    logic [SCHED_W-1:0]  set_sched_load;
    logic [15:0]         sys_factor_short;
    logic [15:0]         sys_factor_mid;
    logic [15:0]         sys_factor_long;
    logic [21:0]         sys_load_short;
    logic [21:0]         sys_load_mid;
    logic [21:0]         sys_load_long;
  } out_t;

  typedef struct packed {
    logic [FAC_W-1:0]   fac;
    logic [LOAD_W-1:0]  load;
    logic [SCHED_W-1:0] sched;
  } row_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
    logic [DIV_DW-1:0]    dividend;
    logic [DIV_SW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/clat_div.sv
// clat_div: shared restoring divider, one quotient bit per cycle
// depends on clat_pkg for the request and response structs
module clat_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clat_pkg::div_req_t req_i,
  output clat_pkg::div_rsp_t rsp_o
);
  import clat_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DW-1:0]    quo_q;
  logic [DIV_SW-1:0]    rem_q;
  logic [DIV_SW-1:0]    dsr_q;
  logic [DIV_SW:0]      trial;
  logic [DIV_SW:0]      diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // left-align the dividend so that count steps consume it
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend << (DIV_CNT_W'(DIV_DW) - req_i.count);
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_DW-2:0], fits};
      rem_q <= fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/cpu_load_average_tracker.sv
// cpu_load_average_tracker: per-set and system load averages, one sampling tick per request
// depends on clat_pkg and clat_div
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one tick for one set;
//   output channel out_valid_o / out_stall_i / out_data_o returns one result per tick.
//   configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), written idle.
// sequence:
//   one request at a time; the shared bit-serial divider sets the pace.
//   a skipped tick goes from accept straight to the result, with no division.
//   a normal tick runs five divisions of 17, 21, 22, 20 and
//   26 quotient bits, each started as the previous one finishes.
//   a tick of the default set adds three rounds for the system averages
//   (each with four multiplies and divisions of 27 and 33 quotient bits).
// reset:
//   all averages read as zero, registers take their reset weights, no result pending.
// stall:
//   a finished result waits in the output register; the next request is accepted
//   meanwhile and holds in its last step until the output register frees up.
module cpu_load_average_tracker #(
  parameter int NUM_SETS = clat_pkg::NUM_SETS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  clat_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output clat_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [clat_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [clat_pkg::CFG_DW-1:0] cfg_data_i
);
  import clat_pkg::*;

  localparam int IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  clat_state_e state_q, state_d;

  // configuration
  logic [SET_W-1:0]   default_set_q;
  logic [SCALE_W-1:0] decay_q [NUM_SYS];

  // request context
  logic [SET_W-1:0]  idx_q;
  logic [CPU_W-1:0]  ncpus_q;
  logic [NTHR_W-1:0] nthr_q;
  logic              is_def_q;
  logic              skip_q;
  row_t              rd_row_q;
  logic              rd_vld_q;

  // intermediate values
  logic [FAC_W-1:0]   fac_q;
  logic [AVG_W-1:0]   avg_q;
  logic [FAC_W-1:0]   new_fac_q;
  logic [LOAD_W-1:0]  new_load_q;
  logic [SCHED_W-1:0] new_sched_q;
  logic [MUL_PW-1:0]  prod_q;
  logic [MUL_PW-1:0]  acc_q;
  logic [SYS_W-1:0]   j_q;

  // stores
  row_t               mem_q [NUM_SETS];
  logic [NUM_SETS-1:0] vld_q;
  logic [FAC_W-1:0]   sys_fac_q  [NUM_SYS];
  logic [LOAD_W-1:0]  sys_load_q [NUM_SYS];

  // output register
  logic out_valid_q;
  out_t out_data_q;

  // accept-time values
  logic [CPU_W-1:0]  ncpus_c;
  logic [WAIT_W-1:0] wait_c;
  logic [CPU_W-1:0]  idle_c;
  logic [NTHR_W-1:0] nthr_raw;
  logic              is_def_c;
  logic [IDX_W-1:0]  in_addr;
  logic [IDX_W-1:0]  addr;

  logic               accept;
  logic               out_free;
  logic               idx_ok;
  logic               skip;
  logic               ge;
  row_t               old_row;
  logic [SCALE_W-1:0] w;
  logic [SCALE_W-1:0] wc;
  logic [MUL_AW-1:0]  mul_a;
  logic [SCALE_W-1:0] mul_b;
  logic [AVG_W-1:0]   sched_sum;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  out_t               result;

  clat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign ncpus_c  = (in_data_i.cpu_count > CPU_W'(MAX_CPUS)) ? CPU_W'(MAX_CPUS)
                                                              : in_data_i.cpu_count;
  assign wait_c   = (in_data_i.waiting_threads > WAIT_W'(MAX_WAITING)) ? WAIT_W'(MAX_WAITING)
                                                                        : in_data_i.waiting_threads;
  assign idle_c   = (in_data_i.idle_cpus > ncpus_c) ? ncpus_c : in_data_i.idle_cpus;
  assign nthr_raw = NTHR_W'(wait_c) + NTHR_W'(ncpus_c - idle_c);
  assign is_def_c = (in_data_i.set_index == default_set_q);
  assign in_addr  = IDX_W'(in_data_i.set_index);
  assign addr     = IDX_W'(idx_q);

  assign idx_ok  = (32'(idx_q) < 32'(NUM_SETS));
  assign skip    = !idx_ok || (ncpus_q == '0);
  assign ge      = (nthr_q >= NTHR_W'(ncpus_q));
  assign old_row = rd_vld_q ? rd_row_q : '0;
  assign w       = (decay_q[j_q] > SCALE_W'(SCALE)) ? SCALE_W'(SCALE) : decay_q[j_q];
  assign wc      = SCALE_W'(SCALE) - w;
  assign sched_sum = AVG_W'(old_row.sched) + AVG_W'(div_rsp.quotient[SCHED_W-1:0]);

  // next state and unit controls
  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (skip) begin
          state_d = ST_OUT;
        end else begin
          mul_a   = ge ? MUL_AW'(ncpus_q) : MUL_AW'(ncpus_q - nthr_q[CPU_W-1:0]);
          mul_b   = SCALE_W'(SCALE);
          state_d = ST_FAC_MUL;
        end
      end
      ST_FAC_MUL: begin
        div_req.start    = 1'b1;
        div_req.count    = DIV_CNT_W'(N_FAC);
        div_req.dividend = DIV_DW'(prod_q);
        div_req.divisor  = ge ? (nthr_q + DIV_SW'(1)) : DIV_SW'(1);
        state_d          = ST_FAC_DIV;
      end
      ST_FAC_DIV: begin
        mul_a = MUL_AW'(nthr_q);
        mul_b = SCALE_W'(SCALE);
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.count    = DIV_CNT_W'(N_SCHED);
          div_req.dividend = ge ? (DIV_DW'(nthr_q) << SCHED_BITS)
                                : (DIV_DW'(ncpus_q) << SCHED_BITS);
          div_req.divisor  = DIV_SW'(ncpus_q);
          state_d          = ST_SCHED_DIV;
        end
      end
      ST_SCHED_DIV: begin
        mul_a = MUL_AW'(nthr_q);
        mul_b = SCALE_W'(SCALE);
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.count    = DIV_CNT_W'(N_AVG);
          div_req.dividend = DIV_DW'(prod_q);
          div_req.divisor  = DIV_SW'(ncpus_q);
          state_d          = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.count    = DIV_CNT_W'(N_SF);
          div_req.dividend = DIV_DW'(old_row.fac) * DIV_DW'(OLD_PARTS) + DIV_DW'(fac_q);
          div_req.divisor  = DIV_SW'(ALL_PARTS);
          state_d          = ST_SF_DIV;
        end
      end
      ST_SF_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.count    = DIV_CNT_W'(N_SL);
          div_req.dividend = DIV_DW'(old_row.load) * DIV_DW'(OLD_PARTS) + DIV_DW'(avg_q);
          div_req.divisor  = DIV_SW'(ALL_PARTS);
          state_d          = ST_SL_DIV;
        end
      end
      ST_SL_DIV: begin
        if (div_rsp.done) begin
          state_d = is_def_q ? ST_SYS_FA : ST_WB;
        end
      end
      ST_SYS_FA: begin
        mul_a   = MUL_AW'(sys_fac_q[j_q]);
        mul_b   = w;
        state_d = ST_SYS_FB;
      end
      ST_SYS_FB: begin
        mul_a   = MUL_AW'(fac_q);
        mul_b   = wc;
        state_d = ST_SYS_FD;
      end
      ST_SYS_FD: begin
        div_req.start    = 1'b1;
        div_req.count    = DIV_CNT_W'(N_SYSF);
        div_req.dividend = DIV_DW'(acc_q + prod_q);
        div_req.divisor  = DIV_SW'(SCALE);
        state_d          = ST_SYS_FW;
      end
      ST_SYS_FW: begin
        mul_a = sys_load_q[j_q];
        mul_b = w;
        if (div_rsp.done) begin
          state_d = ST_SYS_LB;
        end
      end
      ST_SYS_LB: begin
        mul_a   = MUL_AW'(avg_q);
        mul_b   = wc;
        state_d = ST_SYS_LD;
      end
      ST_SYS_LD: begin
        div_req.start    = 1'b1;
        div_req.count    = DIV_CNT_W'(N_SYSL);
        div_req.dividend = DIV_DW'(acc_q + prod_q);
        div_req.divisor  = DIV_SW'(SCALE);
        state_d          = ST_SYS_LW;
      end
      ST_SYS_LW: begin
        if (div_rsp.done) begin
          state_d = (j_q == SYS_W'(NUM_SYS - 1)) ? ST_WB : ST_SYS_FA;
        end
      end
      ST_WB: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_set_q <= '0;
      decay_q[0]    <= SCALE_W'(800);
      decay_q[1]    <= SCALE_W'(966);
      decay_q[2]    <= SCALE_W'(983);
    end else if (cfg_we_i) begin
      unique case (clat_cfg_e'(cfg_idx_i))
        CFG_DEFAULT_SET: default_set_q <= cfg_data_i[SET_W-1:0];
        CFG_DECAY_SHORT: decay_q[0]    <= cfg_data_i;
        CFG_DECAY_MID:   decay_q[1]    <= cfg_data_i;
        CFG_DECAY_LONG:  decay_q[2]    <= cfg_data_i;
        default:         default_set_q <= default_set_q;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      idx_q    <= in_data_i.set_index;
      ncpus_q  <= ncpus_c;
      nthr_q   <= (is_def_c && (nthr_raw != '0)) ? (nthr_raw - NTHR_W'(1)) : nthr_raw;
      is_def_q <= is_def_c;
    end
    if (state_q == ST_LOAD) begin
      skip_q <= skip;
      if (skip) begin
        new_fac_q   <= idx_ok ? old_row.fac   : '0;
        new_load_q  <= idx_ok ? old_row.load  : '0;
        new_sched_q <= idx_ok ? old_row.sched : '0;
      end
    end
    if (div_rsp.done) begin
      unique case (state_q)
        ST_FAC_DIV:   fac_q       <= div_rsp.quotient[FAC_W-1:0];
        ST_SCHED_DIV: new_sched_q <= sched_sum[AVG_W-1:1];
        ST_AVG_DIV:   avg_q       <= div_rsp.quotient[AVG_W-1:0];
        ST_SF_DIV:    new_fac_q   <= div_rsp.quotient[FAC_W-1:0];
        ST_SL_DIV: begin
          new_load_q <= div_rsp.quotient[LOAD_W-1:0];
          j_q        <= '0;
        end
        ST_SYS_LW:    j_q         <= j_q + SYS_W'(1);
        default:      acc_q       <= acc_q;
      endcase
    end
    if ((state_q == ST_SYS_FB) || (state_q == ST_SYS_LB)) begin
      acc_q <= prod_q;
    end
  end

  // per-set store, registered read at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= mem_q[in_addr];
      rd_vld_q <= vld_q[in_addr];
    end
    if (state_q == ST_WB) begin
      mem_q[addr] <= '{fac: new_fac_q, load: new_load_q, sched: new_sched_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == ST_WB) begin
      vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SYS; i++) begin
        sys_fac_q[i]  <= '0;
        sys_load_q[i] <= '0;
      end
    end else if (div_rsp.done) begin
      if (state_q == ST_SYS_FW) begin
        sys_fac_q[j_q] <= div_rsp.quotient[FAC_W-1:0];
      end
      if (state_q == ST_SYS_LW) begin
        sys_load_q[j_q] <= div_rsp.quotient[LOAD_W-1:0];
      end
    end
  end

  // result
  always_comb begin
    result.skipped          = skip_q;
    result.set_factor_avg   = new_fac_q[15:0];
    result.set_load_avg     = new_load_q[21:0];
    result.set_sched_load   = new_sched_q;
    result.sys_factor_short = sys_fac_q[0][15:0];
    result.sys_factor_mid   = sys_fac_q[1][15:0];
    result.sys_factor_long  = sys_fac_q[2][15:0];
    result.sys_load_short   = sys_load_q[0][21:0];
    result.sys_load_mid     = sys_load_q[1][21:0];
    result.sys_load_long    = sys_load_q[2][21:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_data_q <= result;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
